// ===== rtl/direct_mapped_cache_hit_check_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped cache hit check block
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_HIT_CHECK_TOP_MACROS_SVH
`define DIRECT_MAPPED_CACHE_HIT_CHECK_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define DMC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: lbl");
// consequent holds in the cycle after the antecedent
`define DMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define DMC_ASSERT(lbl, clk, rstn, prop)
`define DMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, register codes, state and control types of the cache check.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int MAX_LINES_DEF = 16384;
  localparam int ADDR_W        = 32;
  localparam int TAG_W         = 30;
  localparam int LINE_IDX_W    = 14;
  localparam int CNT_W         = 32;
  localparam int BO_W          = 4;
  localparam int CS_W          = 5;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_IDX_W     = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE   = 1'b1;

  localparam logic [BO_W-1:0] BO_RESET = 4'd4;
  localparam logic [CS_W-1:0] CS_RESET = 5'd12;
  localparam logic [BO_W-1:0] BO_MIN   = 4'd2;
  localparam logic [BO_W-1:0] BO_MAX   = 4'd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clr_we;  // clearing pass writes one line
    logic load;    // latch decoded address
    logic rd_en;   // read tag store
    logic update;  // compare, write on miss, load result
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_stall;
  } sts_t;

endpackage

// ===== rtl/dmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: clearing pass after reset, then accept, lookup, update per word.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dmc_pkg::sts_t sts,
  output dmc_pkg::cmd_t cmd
);

  dmc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dmc_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_done) state_nxt = dmc_pkg::ST_IDLE;
      end
      dmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dmc_pkg::ST_LOOKUP;
        end
      end
      dmc_pkg::ST_LOOKUP: begin
        cmd.rd_en = 1'b1;
        state_nxt = dmc_pkg::ST_UPDATE;
      end
      dmc_pkg::ST_UPDATE: begin
        // hold until the result register is free
        if (!sts.out_stall) begin
          cmd.update = 1'b1;
          state_nxt  = dmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmc_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/dmc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmc_datapath
// Address split, tag store with valid bit, hit compare, counters, result reg.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_hit_check_top_macros.svh"

module dmc_datapath #(
  parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmc_pkg::cmd_t                       cmd,
  output dmc_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [dmc_pkg::ADDR_W-1:0]          in_address,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [dmc_pkg::LINE_IDX_W-1:0]      out_line_index,
  output logic [dmc_pkg::CNT_W-1:0]           out_hit_count,
  output logic [dmc_pkg::CNT_W-1:0]           out_access_count
);

  // index width is floor(log2(MAX_LINES))
  localparam int IDX_W = $clog2(MAX_LINES + 1) - 1;
  localparam int AW    = (IDX_W > 0) ? IDX_W : 1;
  localparam int DEPTH = 2 ** IDX_W;
  localparam int ENT_W = dmc_pkg::TAG_W + 1;
  localparam logic [dmc_pkg::CS_W-1:0] IB_MAX = dmc_pkg::CS_W'(IDX_W);

  // configuration
  logic [dmc_pkg::BO_W-1:0] bo_r;
  logic [dmc_pkg::CS_W-1:0] cs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bo_r <= dmc_pkg::BO_RESET;
      cs_r <= dmc_pkg::CS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dmc_pkg::CFG_BLOCK_OFFSET: bo_r <= cfg_data[dmc_pkg::BO_W-1:0];
        dmc_pkg::CFG_CACHE_SIZE:   cs_r <= cfg_data[dmc_pkg::CS_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [dmc_pkg::BO_W-1:0]   ob;
  logic [dmc_pkg::CS_W-1:0]   ob_ext, ib;
  logic [5:0]                 tag_sh;
  logic [dmc_pkg::ADDR_W-1:0] idx_mask, idx_word, tag_word;

  always_comb begin
    if (bo_r < dmc_pkg::BO_MIN)      ob = dmc_pkg::BO_MIN;
    else if (bo_r > dmc_pkg::BO_MAX) ob = dmc_pkg::BO_MAX;
    else                             ob = bo_r;
    ob_ext = dmc_pkg::CS_W'(ob);
    ib     = (cs_r >= ob_ext) ? cs_r - ob_ext : '0;
    if (ib > IB_MAX) ib = IB_MAX;
    idx_mask = ~({dmc_pkg::ADDR_W{1'b1}} << ib);
    idx_word = (in_address >> ob) & idx_mask;
    tag_sh   = 6'(ob) + 6'(ib);
    tag_word = in_address >> tag_sh;
  end

  logic [AW-1:0]            idx_r;
  logic [dmc_pkg::TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= idx_word[AW-1:0];
      tag_r <= tag_word[dmc_pkg::TAG_W-1:0];
    end
  end

  // clearing pass
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // tag store: {valid, tag}
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_r;
  logic             hit_w, mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ENT_W-1:0] mem_wd;

  assign hit_w  = rd_r[dmc_pkg::TAG_W] && (rd_r[dmc_pkg::TAG_W-1:0] == tag_r);
  assign mem_we = cmd.clr_we || (cmd.update && !hit_w);
  assign mem_wa = cmd.clr_we ? clr_cnt_r : idx_r;
  assign mem_wd = cmd.clr_we ? '0 : {1'b1, tag_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd_en) rd_r <= mem[idx_r];
  end

  // counters
  logic [dmc_pkg::CNT_W-1:0] hits_r, acc_r, hits_nxt, acc_nxt;

  always_comb begin
    acc_nxt  = (acc_r == '1) ? acc_r : acc_r + dmc_pkg::CNT_W'(1);
    hits_nxt = hits_r;
    if (hit_w && hits_r != '1) hits_nxt = hits_r + dmc_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
      acc_r  <= '0;
    end else if (cmd.update) begin
      hits_r <= hits_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // result register
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [dmc_pkg::LINE_IDX_W-1:0]    out_line_r;
  logic [dmc_pkg::CNT_W-1:0]         out_hits_r, out_acc_r;
  logic [31:0]                       idx_ext;

  assign idx_ext = 32'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r  <= hit_w;
      out_line_r <= idx_ext[dmc_pkg::LINE_IDX_W-1:0];
      out_hits_r <= hits_nxt;
      out_acc_r  <= acc_nxt;
    end
  end

  assign sts.clr_done  = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.out_stall = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_line_index   = out_line_r;
  assign out_hit_count    = out_hits_r;
  assign out_access_count = out_acc_r;

  `DMC_ASSERT_NEXT(a_update_shows, clk, rst_n, cmd.update, out_valid_r)
  `DMC_ASSERT(a_hits_le_acc, clk, rst_n, hits_r <= acc_r)
  `DMC_ASSERT_NEXT(a_acc_steps, clk, rst_n, cmd.update,
                   (acc_r == $past(acc_r) + 32'd1) || (acc_r == '1))
  `DMC_ASSERT(a_clear_alone, clk, rst_n,
              !(cmd.clr_we && (cmd.update || cmd.load || cmd.rd_en)))

endmodule

// ===== rtl/direct_mapped_cache_hit_check_top.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_check_top
// Direct-mapped cache tag lookup with saturating hit and access counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one 32-bit byte address per word.
//   Result channel (out_valid/out_ready) returns hit, line index and the
//   running hit and access counts, one result word per input word.
//   cfg_we/cfg_index/cfg_data write block_offset_bits (index 0) and
//   cache_size_bits (index 1); write only while the block is idle.
// Sequence:
//   An accepted word is latched by the address decode, its tag store line
//   is read, then compare and update load the result register once it is
//   free. The next word is accepted only after that update, so a word is
//   not taken while the last one is still being looked up.
// Reset:
//   Counters and configuration go to their defaults, then a clearing pass
//   writes all 2^floor(log2(MAX_LINES)) lines invalid (16384 by default),
//   one line per cycle. in_ready stays low during the pass.
// Stall:
//   The result register holds while out_ready is low; one more word can be
//   taken and looked up, then the update waits for the register to drain.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_check_top #(
  parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dmc_pkg::ADDR_W-1:0]     in_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [dmc_pkg::LINE_IDX_W-1:0] out_line_index,
  output logic [dmc_pkg::CNT_W-1:0]      out_hit_count,
  output logic [dmc_pkg::CNT_W-1:0]      out_access_count
);

  dmc_pkg::cmd_t cmd;
  dmc_pkg::sts_t sts;

  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmc_datapath #(
    .MAX_LINES (MAX_LINES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_address       (in_address),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_line_index   (out_line_index),
    .out_hit_count    (out_hit_count),
    .out_access_count (out_access_count)
  );

endmodule
